>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the cidr filter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CADF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true
`define CADF_NEVER(lbl, clk, rst_n, expr, msg) \
	`CADF_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

>>> design/cadf_pkg.sv
// ----------------------------------------------------------------------------
// cadf_pkg
// shared types and codes of the cidr allow/deny filter
// ----------------------------------------------------------------------------
package cadf_pkg;

	localparam logic [1:0] FUNC_CHECK     = 2'd0;
	localparam logic [1:0] FUNC_ADD_ALLOW = 2'd1;
	localparam logic [1:0] FUNC_ADD_DENY  = 2'd2;
	localparam logic [1:0] FUNC_CLEAR     = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

	localparam logic REG_FILTER_ENABLE      = 1'b0;
	localparam logic REG_USER_LISTS_PRESENT = 1'b1;

	localparam int IN_DATA_W  = 144;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 8;

	localparam logic [7:0] V4_MAX_LEN = 8'd32;
	localparam logic [7:0] V6_MAX_LEN = 8'd128;

	typedef struct packed {
		logic [8:0]  tag;
		logic [63:0] hi;
		logic [63:0] lo;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_step;
		logic result_load;
	} cmd_t;

	typedef struct packed {
		logic is_check;
		logic scan_done;
	} sts_t;

endpackage

>>> design/cidr_allow_deny_filter.sv
// ----------------------------------------------------------------------------
// cidr_allow_deny_filter
// allow and deny lists of ipv4/ipv6 prefixes with address admission checks
// ----------------------------------------------------------------------------
// the s_ group takes one item per transfer: tuser selects the function and
// family, tdata carries the address, prefix length and local flag. every item
// gives exactly one result transfer on the m_ group (verdict, hits, status).
// cfg_we writes filter_enable (index 0) or user_lists_present (index 1) from
// bit 0 of cfg_data; the user must write only while no item is in flight, the
// block does not enforce it. one item is worked at a time. a check walks both
// entry memories in step, one entry each per cycle through their single read
// ports. each item passes capture, execute, the list walk (checks only) and
// the result load; m_tvalid rises once the result is loaded, and the next
// item is taken only after that load.
// reset empties both lists, clears both registers and drops m_tvalid; entry
// memories are not cleared, entries past a list's fill count are never used.
// if the receiver stalls, the result waits in the output register while the
// next item is already taken and worked; its own result waits for the slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidr_allow_deny_filter #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// addr_high, addr_low, prefix_len, from_local, zero pad
	input  logic [cadf_pkg::IN_DATA_W-1:0]  s_tdata,
	// func, is_ipv6
	input  logic [cadf_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// allowed, allow_hit, deny_hit, status, zero pad
	output logic [cadf_pkg::OUT_DATA_W-1:0] m_tdata
);
	import cadf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cadf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cadf_dp #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

	`CADF_ASSERT(a_busy_after_accept, clk, arst_n,
		(s_tvalid && s_tready) |=> !s_tready, "ready after accept")
	`CADF_NEVER(a_capture_during_work, clk, arst_n,
		cmd.capture && (cmd.exec || cmd.scan_step || cmd.result_load),
		"capture overlaps work")
	`CADF_ASSERT(a_status_code, clk, arst_n,
		m_tvalid |-> (m_tdata[4:3] == STATUS_OK || m_tdata[4:3] == STATUS_FULL ||
		m_tdata[4:3] == STATUS_TOO_LONG), "bad status code")

endmodule

>>> design/cadf_ctrl.sv
// ----------------------------------------------------------------------------
// cadf_ctrl
// sequencer: accept, execute, list walk, result hand-off
// ----------------------------------------------------------------------------
module cadf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  cadf_pkg::sts_t sts,
	output cadf_pkg::cmd_t cmd
);
	import cadf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.is_check ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/cadf_dp.sv
// ----------------------------------------------------------------------------
// cadf_dp
// item register, entry memories, prefix matcher, verdict and result register
// ----------------------------------------------------------------------------
module cadf_dp #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic                            cfg_data,
	input  logic [cadf_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [cadf_pkg::IN_USER_W-1:0]  s_tuser,
	output logic [cadf_pkg::OUT_DATA_W-1:0] m_tdata,
	input  cadf_pkg::cmd_t                  cmd,
	output cadf_pkg::sts_t                  sts
);
	import cadf_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	function automatic logic prefix_match(input logic v6, input logic [63:0] hi,
			input logic [63:0] lo, input entry_t e);
		logic [7:0]  len;
		logic [31:0] m4;
		logic [63:0] mhi;
		logic [63:0] mlo;
		logic        hit;
		len = e.tag[7:0];
		m4  = '0;
		mhi = '0;
		mlo = '0;
		if (e.tag[8] != v6) begin
			hit = 1'b0;
		end else if (!v6) begin
			if (len > V4_MAX_LEN)
				len = V4_MAX_LEN;
			if (len != 8'd0)
				m4 = ~32'd0 << (V4_MAX_LEN - len);
			hit = ((lo[31:0] ^ e.lo[31:0]) & m4) == 32'd0;
		end else begin
			if (len > V6_MAX_LEN)
				len = V6_MAX_LEN;
			if (len >= 8'd64)
				mhi = ~64'd0;
			else if (len != 8'd0)
				mhi = ~64'd0 << (8'd64 - len);
			if (len >= V6_MAX_LEN)
				mlo = ~64'd0;
			else if (len > 8'd64)
				mlo = ~64'd0 << (V6_MAX_LEN - len);
			hit = (((hi ^ e.hi) & mhi) == 64'd0) && (((lo ^ e.lo) & mlo) == 64'd0);
		end
		return hit;
	endfunction

	// configuration
	logic en_q;
	logic ulp_q;

	// current item
	logic [1:0]  func_q;
	logic        v6_q;
	logic [63:0] hi_q;
	logic [63:0] lo_q;
	logic [7:0]  plen_q;
	logic        local_q;

	// list state
	entry_t        allow_mem [LIST_DEPTH];
	entry_t        deny_mem  [LIST_DEPTH];
	logic [CW-1:0] acnt_q;
	logic [CW-1:0] dcnt_q;
	logic [CW-1:0] scan_q;
	entry_t        ard_s1;
	entry_t        drd_s1;
	logic          avld_s1;
	logic          dvld_s1;
	logic          ahit_q;
	logic          dhit_q;
	logic [1:0]    st_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic   too_long;
	logic   afull;
	logic   dfull;
	logic   a_we;
	logic   d_we;
	entry_t wr_entry;
	logic   ahit_now;
	logic   dhit_now;
	logic   verdict;

	assign too_long = v6_q ? (plen_q > V6_MAX_LEN) : (plen_q > V4_MAX_LEN);
	assign afull    = (acnt_q == CW'(LIST_DEPTH));
	assign dfull    = (dcnt_q == CW'(LIST_DEPTH));
	assign a_we     = cmd.exec && (func_q == FUNC_ADD_ALLOW) && !too_long && !afull;
	assign d_we     = cmd.exec && (func_q == FUNC_ADD_DENY) && !too_long && !dfull;
	assign wr_entry = '{tag: {v6_q, plen_q}, hi: hi_q, lo: lo_q};

	assign ahit_now = ahit_q || (avld_s1 && prefix_match(v6_q, hi_q, lo_q, ard_s1));
	assign dhit_now = dhit_q || (dvld_s1 && prefix_match(v6_q, hi_q, lo_q, drd_s1));

	assign verdict = !(en_q && !local_q &&
		(((acnt_q != '0) && !ahit_q && !ulp_q) || dhit_q));

	assign sts.is_check  = (func_q == FUNC_CHECK);
	assign sts.scan_done = (scan_q == CW'(LIST_DEPTH));
	assign m_tdata       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			ulp_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_FILTER_ENABLE)
				en_q <= cfg_data;
			if (cfg_index == REG_USER_LISTS_PRESENT)
				ulp_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q  <= s_tuser[1:0];
			v6_q    <= s_tuser[2];
			hi_q    <= s_tuser[2] ? s_tdata[63:0] : 64'd0;
			lo_q    <= s_tuser[2] ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
			plen_q  <= s_tdata[135:128];
			local_q <= s_tdata[136];
		end
	end

	always_ff @(posedge clk) begin
		if (a_we)
			allow_mem[acnt_q[AW-1:0]] <= wr_entry;
		if (d_we)
			deny_mem[dcnt_q[AW-1:0]] <= wr_entry;
		if (cmd.scan_step && (scan_q < CW'(LIST_DEPTH))) begin
			ard_s1 <= allow_mem[scan_q[AW-1:0]];
			drd_s1 <= deny_mem[scan_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acnt_q  <= '0;
			dcnt_q  <= '0;
			scan_q  <= '0;
			avld_s1 <= 1'b0;
			dvld_s1 <= 1'b0;
			ahit_q  <= 1'b0;
			dhit_q  <= 1'b0;
			st_q    <= STATUS_OK;
		end else begin
			if (cmd.exec) begin
				scan_q  <= '0;
				avld_s1 <= 1'b0;
				dvld_s1 <= 1'b0;
				ahit_q  <= 1'b0;
				dhit_q  <= 1'b0;
				st_q    <= STATUS_OK;
				if (func_q == FUNC_CLEAR) begin
					acnt_q <= '0;
					dcnt_q <= '0;
				end else if (func_q != FUNC_CHECK) begin
					if (too_long)
						st_q <= STATUS_TOO_LONG;
					else if ((func_q == FUNC_ADD_ALLOW) ? afull : dfull)
						st_q <= STATUS_FULL;
				end
				if (a_we)
					acnt_q <= acnt_q + CW'(1);
				if (d_we)
					dcnt_q <= dcnt_q + CW'(1);
			end
			if (cmd.scan_step) begin
				scan_q  <= scan_q + CW'(1);
				ahit_q  <= ahit_now;
				dhit_q  <= dhit_now;
				avld_s1 <= (scan_q < acnt_q);
				dvld_s1 <= (scan_q < dcnt_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			if (func_q == FUNC_CHECK)
				out_q <= {3'd0, STATUS_OK, dhit_q, ahit_q, verdict};
			else
				out_q <= {3'd0, st_q, 1'b0, 1'b0, 1'b1};
		end
	end

endmodule
